### rtl/sabo_pkg.sv
package sabo_pkg;

  // Pixel channel width and lane layout (red, green, blue, alpha)
  localparam int PIX_W   = 8;
  localparam int LANES   = 4;
  localparam int COLORS  = 3;
  localparam int LANE_R  = 0;
  localparam int LANE_G  = 1;
  localparam int LANE_B  = 2;
  localparam int LANE_A  = 3;

  // Coverage C = mask * alpha is a fraction over 255 * 255
  localparam int COV_W = 16;
  localparam logic [COV_W-1:0] FULL16 = 16'd65025;

  // Output alpha O is a fraction over 255 * 65025 and fits 24 bits
  localparam int OUT_A_W = 24;

  // Rounded divide: quotient = floor((2N + O) / (2O)), always below 256
  localparam int REM_W = 33;
  localparam int DEN_W = 25;
  localparam int QUO_W = 8;

  // Alpha lane: round(O / 65025) = floor((2O + 65025) / 130050), taken as a
  // multiply by ceil(2^42 / 130050) and a shift, exact for any 25-bit dividend
  localparam int ANUM_W = 25;
  localparam int ARCP_W = 26;
  localparam int ASHIFT = 42;
  localparam int APRD_W = ASHIFT + QUO_W;
  localparam logic [ANUM_W-1:0] ALPHA_BIAS = 25'd65025;
  localparam logic [ARCP_W-1:0] ALPHA_RCP  = 26'd33818121;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } sabo_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } sabo_cfg_t;

  // One item in flight through the divider
  typedef struct packed {
    logic [LANES-1:0][REM_W-1:0] rem;
    logic [LANES-1:0][DEN_W-1:0] den;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic                        bypass;
    logic [LANES-1:0][PIX_W-1:0] dest;
  } sabo_div_t;

endpackage

### rtl/sabo_pixel_if.sv
interface sabo_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] mask_coverage;
  logic [7:0] dest_red;
  logic [7:0] dest_green;
  logic [7:0] dest_blue;
  logic [7:0] dest_alpha;

  modport source (
    output valid, mask_coverage, dest_red, dest_green, dest_blue, dest_alpha,
    input  ready
  );

  modport sink (
    input  valid, mask_coverage, dest_red, dest_green, dest_blue, dest_alpha,
    output ready
  );
endinterface

### rtl/sabo_result_if.sv
interface sabo_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] blended_red;
  logic [7:0] blended_green;
  logic [7:0] blended_blue;
  logic [7:0] blended_alpha;
  logic       pixel_changed;

  modport source (
    output valid, blended_red, blended_green, blended_blue, blended_alpha,
           pixel_changed,
    input  ready
  );

  modport sink (
    input  valid, blended_red, blended_green, blended_blue, blended_alpha,
           pixel_changed,
    output ready
  );
endinterface

### rtl/sabo_weigh.sv
module sabo_weigh (
  input  logic                                          clk,
  input  logic                                          rst,
  input  sabo_pkg::sabo_cfg_t                           cfg,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [sabo_pkg::PIX_W-1:0]                    mask,
  input  logic [sabo_pkg::LANES-1:0][sabo_pkg::PIX_W-1:0] dest,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output sabo_pkg::sabo_div_t                           out_data
);

  localparam int CW = sabo_pkg::COV_W;
  localparam int OW = sabo_pkg::OUT_A_W;
  localparam int RW = sabo_pkg::REM_W;
  localparam int DW = sabo_pkg::DEN_W;
  localparam int PW = 2 * CW;
  localparam int AW = sabo_pkg::APRD_W;
  localparam int QW = sabo_pkg::QUO_W;

  // Stage 1: coverage
  logic                                                   v1;
  logic [CW-1:0]                                          cov1;
  logic [sabo_pkg::LANES-1:0][sabo_pkg::PIX_W-1:0]        dest1;
  logic [sabo_pkg::COLORS-1:0][sabo_pkg::PIX_W-1:0]       src1;

  // Stage 2: first products
  logic                                                   v2;
  logic [CW-1:0]                                          inv2;
  logic [OW-1:0]                                          c255_2;
  logic [OW-1:0]                                          w2;
  logic [sabo_pkg::COLORS-1:0][OW-1:0]                    sc2;
  logic [sabo_pkg::COLORS-1:0][CW-1:0]                    dd2;
  logic                                                   byp2;
  logic [sabo_pkg::LANES-1:0][sabo_pkg::PIX_W-1:0]        dest2;

  // Stage 3: output alpha and second products
  logic                                                   v3;
  logic [OW-1:0]                                          o3;
  logic [sabo_pkg::COLORS-1:0][PW-1:0]                    p3;
  logic [sabo_pkg::COLORS-1:0][PW-1:0]                    s3;
  logic                                                   byp3;
  logic [sabo_pkg::LANES-1:0][sabo_pkg::PIX_W-1:0]        dest3;

  logic                                                   r1;
  logic                                                   r2;
  logic                                                   r3;
  logic                                                   r4;
  logic [CW-1:0]                                          inv1;
  logic [sabo_pkg::COLORS-1:0][PW:0]                      nsum;
  logic [sabo_pkg::ANUM_W-1:0]                            anum;
  logic [AW-1:0]                                          aprod;

  // Advance a stage whenever it is empty or the next one moves
  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  // Stage 1: mask times paint alpha
  always_ff @(posedge clk) begin
    if (r1) begin
      cov1  <= CW'(mask) * CW'(cfg.alpha);
      dest1 <= dest;
      src1  <= {cfg.blue, cfg.green, cfg.red};
    end
  end

  assign inv1 = sabo_pkg::FULL16 - cov1;

  // Stage 2: source and destination weights
  always_ff @(posedge clk) begin
    if (r2) begin
      inv2   <= inv1;
      c255_2 <= {cov1, 8'd0} - OW'(cov1);
      w2     <= OW'(dest1[sabo_pkg::LANE_A]) * OW'(inv1);
      for (int k = 0; k < sabo_pkg::COLORS; k++) begin
        sc2[k] <= OW'(src1[k]) * OW'(cov1);
        dd2[k] <= CW'(dest1[k]) * CW'(dest1[sabo_pkg::LANE_A]);
      end
      byp2  <= (cov1 == '0);
      dest2 <= dest1;
    end
  end

  // Stage 3: output alpha, destination term and scaled source term
  always_ff @(posedge clk) begin
    if (r3) begin
      o3 <= c255_2 + w2;
      for (int k = 0; k < sabo_pkg::COLORS; k++) begin
        p3[k] <= PW'(dd2[k]) * PW'(inv2);
        s3[k] <= {sc2[k], 8'd0} - PW'(sc2[k]);
      end
      byp3  <= byp2;
      dest3 <= dest2;
    end
  end

  // Stage 4: build color dividends and divisors, round alpha by reciprocal
  always_comb begin
    for (int k = 0; k < sabo_pkg::COLORS; k++) begin
      nsum[k] = (PW+1)'(s3[k]) + (PW+1)'(p3[k]);
    end
    anum  = {o3, 1'b0} + sabo_pkg::ALPHA_BIAS;
    aprod = AW'(anum) * AW'(sabo_pkg::ALPHA_RCP);
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      for (int k = 0; k < sabo_pkg::COLORS; k++) begin
        out_data.rem[k] <= RW'({nsum[k], 1'b0}) + RW'(o3);
        out_data.den[k] <= DW'({o3, 1'b0});
        out_data.quo[k] <= '0;
      end
      out_data.rem[sabo_pkg::LANE_A] <= '0;
      out_data.den[sabo_pkg::LANE_A] <= '0;
      out_data.quo[sabo_pkg::LANE_A] <= QW'(aprod >> sabo_pkg::ASHIFT);
      out_data.bypass <= byp3;
      out_data.dest   <= dest3;
    end
  end

endmodule

### rtl/sabo_div.sv
module sabo_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sabo_pkg::sabo_div_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sabo_pkg::sabo_div_t out_data
);

  localparam int RW    = sabo_pkg::REM_W;
  localparam int STEPS = sabo_pkg::QUO_W;
  localparam int BW    = $clog2(STEPS);

  sabo_pkg::sabo_div_t stg [STEPS];
  logic                vld [STEPS];
  logic                rdy [STEPS];

  // One restoring step on every color lane: try the divisor at bit position b
  function automatic sabo_pkg::sabo_div_t div_step(input sabo_pkg::sabo_div_t d,
                                                   input logic [BW-1:0] b);
    sabo_pkg::sabo_div_t r;
    logic [RW-1:0]       sh;
    r = d;
    for (int k = 0; k < sabo_pkg::COLORS; k++) begin
      sh = RW'(d.den[k]) << b;
      if (d.rem[k] >= sh) begin
        r.rem[k]    = d.rem[k] - sh;
        r.quo[k][b] = 1'b1;
      end
    end
    return r;
  endfunction

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    sabo_pkg::sabo_div_t prev;
    logic                prev_v;

    if (j == 0) begin : g_first
      assign prev   = in_data;
      assign prev_v = in_valid;
    end else begin : g_next
      assign prev   = stg[j-1];
      assign prev_v = vld[j-1];
    end

    if (j == STEPS - 1) begin : g_last
      assign rdy[j] = !vld[j] || out_ready;
    end else begin : g_mid
      assign rdy[j] = !vld[j] || rdy[j+1];
    end

    // Advance valid with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= prev_v;
      end
    end

    // Resolve one quotient bit, most significant first
    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        stg[j] <= div_step(prev, BW'(STEPS - 1 - j));
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[STEPS-1];
  assign out_data  = stg[STEPS-1];

endmodule

### rtl/straight_alpha_over_blend_unit.sv
// Straight-alpha "over" blend of a configured paint color onto RGBA8
// destination pixels, weighted by an 8-bit mask coverage. The unit takes one
// pixel per clock unless a stall has filled every stage, and returns one
// result per pixel in order, through coverage, weight and dividend arithmetic
// followed by an eight-step restoring divider that resolves one quotient bit
// per stage on the three color channels at once. Output alpha is a divide by
// a constant, done by a reciprocal multiply in the stage that builds the color
// dividends, and carried along beside the color lanes.
// Every stage holds its own valid bit, so bubbles close up during a stall and
// a new pixel is taken as long as any stage ahead has room. Pixels with zero
// coverage pass through unchanged with pixel_changed low. Paint registers are
// written through the plain write port and must only change while no pixel is
// in flight.
module straight_alpha_over_blend_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [1:0]                   write_index,
  input  logic [sabo_pkg::PIX_W-1:0]   write_data,
  sabo_pixel_if.sink                   pixel,
  sabo_result_if.source                result
);

  sabo_pkg::sabo_cfg_t cfg;
  logic                mid_valid;
  logic                mid_ready;
  sabo_pkg::sabo_div_t mid_data;
  sabo_pkg::sabo_div_t fin_data;
  logic [sabo_pkg::LANES-1:0][sabo_pkg::PIX_W-1:0] dest;

  // Paint color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red   <= 8'd0;
      cfg.green <= 8'd0;
      cfg.blue  <= 8'd0;
      cfg.alpha <= 8'd255;
    end else if (write_enable) begin
      case (sabo_pkg::sabo_reg_t'(write_index))
        sabo_pkg::REG_RED:   cfg.red   <= write_data;
        sabo_pkg::REG_GREEN: cfg.green <= write_data;
        sabo_pkg::REG_BLUE:  cfg.blue  <= write_data;
        sabo_pkg::REG_ALPHA: cfg.alpha <= write_data;
        default: ;
      endcase
    end
  end

  assign dest = {pixel.dest_alpha, pixel.dest_blue, pixel.dest_green, pixel.dest_red};

  sabo_weigh u_weigh (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .mask      (pixel.mask_coverage),
    .dest      (dest),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  sabo_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (fin_data)
  );

  // Pick the blended pixel, or the untouched destination on zero coverage
  always_comb begin
    if (fin_data.bypass) begin
      result.blended_red   = fin_data.dest[sabo_pkg::LANE_R];
      result.blended_green = fin_data.dest[sabo_pkg::LANE_G];
      result.blended_blue  = fin_data.dest[sabo_pkg::LANE_B];
      result.blended_alpha = fin_data.dest[sabo_pkg::LANE_A];
      result.pixel_changed = 1'b0;
    end else begin
      result.blended_red   = fin_data.quo[sabo_pkg::LANE_R];
      result.blended_green = fin_data.quo[sabo_pkg::LANE_G];
      result.blended_blue  = fin_data.quo[sabo_pkg::LANE_B];
      result.blended_alpha = fin_data.quo[sabo_pkg::LANE_A];
      result.pixel_changed = 1'b1;
    end
  end

endmodule

### rtl/sabo_checker.sv
module sabo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] out_data
);

  // No result is shown in the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled, full output
  assert property (@(posedge clk) disable iff (rst)
                   !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output can drain");

  // Hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat dropped or changed");

  // Never show unknown bits on a valid result beat
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> !$isunknown(out_data))
    else $error("result beat carries unknown bits");

endmodule

bind straight_alpha_over_blend_unit sabo_checker u_sabo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  ({result.blended_red, result.blended_green, result.blended_blue,
               result.blended_alpha, result.pixel_changed})
);

### sim/blend_checker.sv
`timescale 1ns / 100ps

module blend_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_enable,
  input  logic [1:0]                  write_index,
  input  logic [sabo_pkg::PIX_W-1:0]  write_data,
  sabo_pixel_if                       pixel,
  sabo_result_if                      result,
  output int unsigned                 mismatches,
  output int unsigned                 pending
);

  localparam bit [63:0] OPAQUE    = 64'd255;
  localparam bit [63:0] OPAQUE_SQ = 64'd65025;

  typedef struct packed {
    logic [sabo_pkg::PIX_W-1:0] red;
    logic [sabo_pkg::PIX_W-1:0] green;
    logic [sabo_pkg::PIX_W-1:0] blue;
    logic [sabo_pkg::PIX_W-1:0] alpha;
    logic                       changed;
  } blended_t;

  sabo_pkg::sabo_cfg_t paint;
  blended_t            blended_q[$];
  blended_t            seen_px;
  blended_t            oldest_px;

  // One color lane: weighted mean of paint and destination, rounded half up
  function automatic logic [sabo_pkg::PIX_W-1:0] mix_lane(
      input logic [sabo_pkg::PIX_W-1:0] paint_c,
      input logic [sabo_pkg::PIX_W-1:0] dest_c,
      input logic [sabo_pkg::PIX_W-1:0] dest_a,
      input bit [63:0]                  cover_w,
      input bit [63:0]                  out_a);
    bit [63:0] num;
    bit [63:0] quo;
    if (out_a == 0) return '0;
    num = 64'(paint_c) * cover_w * OPAQUE
        + 64'(dest_c) * 64'(dest_a) * (OPAQUE_SQ - cover_w);
    quo = (2 * num + out_a) / (2 * out_a);
    return (quo > OPAQUE) ? 8'd255 : quo[sabo_pkg::PIX_W-1:0];
  endfunction

  // Composite the paint over one destination pixel
  function automatic blended_t blend_over(input sabo_pkg::sabo_cfg_t p,
                                          input logic [sabo_pkg::PIX_W-1:0] m,
                                          input logic [sabo_pkg::PIX_W-1:0] r,
                                          input logic [sabo_pkg::PIX_W-1:0] g,
                                          input logic [sabo_pkg::PIX_W-1:0] b,
                                          input logic [sabo_pkg::PIX_W-1:0] a);
    bit [63:0] cover_w;
    bit [63:0] out_a;
    bit [63:0] alpha_r;
    blended_t  res;
    cover_w = 64'(m) * 64'(p.alpha);
    if (cover_w == 0) begin
      // no coverage: destination passes untouched
      res = '{red: r, green: g, blue: b, alpha: a, changed: 1'b0};
      return res;
    end
    out_a   = cover_w * OPAQUE + 64'(a) * (OPAQUE_SQ - cover_w);
    alpha_r = (2 * out_a + OPAQUE_SQ) / (2 * OPAQUE_SQ);
    if (alpha_r > OPAQUE) alpha_r = OPAQUE;
    res.red     = mix_lane(p.red, r, a, cover_w, out_a);
    res.green   = mix_lane(p.green, g, a, cover_w, out_a);
    res.blue    = mix_lane(p.blue, b, a, cover_w, out_a);
    res.alpha   = alpha_r[sabo_pkg::PIX_W-1:0];
    res.changed = 1'b1;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input blended_t want, input blended_t got);
    if (mismatches < 10)
      $display({"%0t: %s: expected r=%0d g=%0d b=%0d a=%0d chg=%0d,",
                " got r=%0d g=%0d b=%0d a=%0d chg=%0d"},
               $realtime, what, want.red, want.green, want.blue, want.alpha, want.changed,
               got.red, got.green, got.blue, got.alpha, got.changed);
    mismatches <= mismatches + 1;
  endtask

  // Track the paint, predict each pixel beat, compare each result beat
  always @(posedge clk) begin
    if (rst) begin
      paint      <= '{red: '0, green: '0, blue: '0, alpha: 8'd255};
      blended_q.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      // compare first so a result never meets the pixel taken at this edge
      if (result.valid && result.ready) begin
        seen_px = '{red: result.blended_red, green: result.blended_green,
                    blue: result.blended_blue, alpha: result.blended_alpha,
                    changed: result.pixel_changed};
        if (blended_q.size() == 0) begin
          note_mismatch("result with no pixel outstanding", '0, seen_px);
        end else begin
          oldest_px = blended_q.pop_front();
          if (seen_px !== oldest_px) note_mismatch("mismatch", oldest_px, seen_px);
        end
      end
      if (pixel.valid && pixel.ready)
        blended_q = {blended_q,
                     blend_over(paint, pixel.mask_coverage, pixel.dest_red,
                                pixel.dest_green, pixel.dest_blue, pixel.dest_alpha)};
      if (write_enable) begin
        case (write_index)
          sabo_pkg::REG_RED:   paint.red   <= write_data;
          sabo_pkg::REG_GREEN: paint.green <= write_data;
          sabo_pkg::REG_BLUE:  paint.blue  <= write_data;
          sabo_pkg::REG_ALPHA: paint.alpha <= write_data;
          default: ;
        endcase
      end
      pending <= blended_q.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       write_enable = 1'b0;
  logic [1:0]                 write_index = sabo_pkg::REG_RED;
  logic [sabo_pkg::PIX_W-1:0] write_data = '0;
  bit                         steady = 1'b0;
  int unsigned                mismatches;
  int unsigned                pending;

  sabo_pixel_if  pixel_bus ();
  sabo_result_if result_bus ();

  straight_alpha_over_blend_unit dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel        (pixel_bus),
    .result       (result_bus)
  );

  blend_checker blend_check (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel        (pixel_bus),
    .result       (result_bus),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random unless in the steady stretch
  always @(posedge clk) begin
    result_bus.ready <= steady || ($urandom_range(99) >= 21);
  end

  // Offer one pixel beat, with random gaps ahead of it, and hold until taken
  task automatic send_pixel(input logic [sabo_pkg::PIX_W-1:0] m,
                            input logic [sabo_pkg::PIX_W-1:0] r,
                            input logic [sabo_pkg::PIX_W-1:0] g,
                            input logic [sabo_pkg::PIX_W-1:0] b,
                            input logic [sabo_pkg::PIX_W-1:0] a);
    bit took;
    while (!steady && $urandom_range(99) < 21) begin
      pixel_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_bus.valid         <= 1'b1;
    pixel_bus.mask_coverage <= m;
    pixel_bus.dest_red      <= r;
    pixel_bus.dest_green    <= g;
    pixel_bus.dest_blue     <= b;
    pixel_bus.dest_alpha    <= a;
    do begin
      @(negedge clk);
      took = pixel_bus.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Mostly partial coverage, with the extremes of mask and alpha mixed in
  task automatic send_random();
    int                         sel;
    logic [sabo_pkg::PIX_W-1:0] m;
    logic [sabo_pkg::PIX_W-1:0] a;
    sel = $urandom_range(9);
    m = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : (sel == 2) ? 8'd1 : 8'($urandom_range(255));
    sel = $urandom_range(9);
    a = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(255));
    send_pixel(m, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), a);
  endtask

  // Drop valid and hold off until every result is back
  task automatic drain();
    pixel_bus.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Write all four paint registers on back-to-back edges
  task automatic set_paint(input logic [sabo_pkg::PIX_W-1:0] r,
                           input logic [sabo_pkg::PIX_W-1:0] g,
                           input logic [sabo_pkg::PIX_W-1:0] b,
                           input logic [sabo_pkg::PIX_W-1:0] a);
    write_enable <= 1'b1;
    write_index  <= sabo_pkg::REG_RED;
    write_data   <= r;
    @(posedge clk);
    write_index  <= sabo_pkg::REG_GREEN;
    write_data   <= g;
    @(posedge clk);
    write_index  <= sabo_pkg::REG_BLUE;
    write_data   <= b;
    @(posedge clk);
    write_index  <= sabo_pkg::REG_ALPHA;
    write_data   <= a;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  initial begin
    pixel_bus.valid         = 1'b0;
    pixel_bus.mask_coverage = '0;
    pixel_bus.dest_red      = '0;
    pixel_bus.dest_green    = '0;
    pixel_bus.dest_blue     = '0;
    pixel_bus.dest_alpha    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset paint: opaque black
    send_pixel(8'd0, 8'd12, 8'd34, 8'd56, 8'd78);        // zero mask passes through
    send_pixel(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);          // full cover on transparent
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd255, 8'd255, 8'd255, 8'd255);    // smallest coverage
    send_pixel(8'd128, 8'd200, 8'd100, 8'd50, 8'd0);     // transparent destination
    send_pixel(8'd128, 8'd200, 8'd100, 8'd50, 8'd255);
    send_pixel(8'd254, 8'd1, 8'd2, 8'd3, 8'd1);
    send_pixel(8'd127, 8'd255, 8'd0, 8'd255, 8'd128);
    send_pixel(8'd2, 8'd170, 8'd85, 8'd255, 8'd254);
    drain();

    // Half-transparent paint
    set_paint(8'd255, 8'd128, 8'd1, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd9, 8'd9, 8'd9, 8'd9);
    send_pixel(8'd64, 8'd10, 8'd200, 8'd30, 8'd100);
    send_pixel(8'd255, 8'd128, 8'd128, 8'd128, 8'd128);
    send_pixel(8'd200, 8'd255, 8'd0, 8'd0, 8'd1);
    send_pixel(8'd3, 8'd0, 8'd0, 8'd0, 8'd255);
    drain();

    // Random phases, each under its own paint
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_paint(8'd255, 8'd255, 8'd255, 8'd255);
        1: set_paint(8'd0, 8'd0, 8'd0, 8'd0);            // zero paint alpha
        2: set_paint(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'd1);
        default: set_paint(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)),
                           $urandom_range(1) ? 8'd255 : 8'($urandom_range(255)));
      endcase
      steady <= (phase == 4);
      repeat (235) send_random();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up on a hung handshake
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
